// ===== sv/bprp_pkg.sv =====
// Package for the bit-packed record parser: types, codes and record layout functions.
// Used by the controller, the datapath, the top level, the checker and the testbench.
package bprp_pkg;

  localparam int MaxFieldBitsDef = 31;
  localparam logic [4:0] IdEmpty = 5'd18;

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_MATRIX = 2'd1,
    KIND_CX     = 2'd2,
    KIND_CXA    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    IT_NONE,
    IT_FLAG,
    IT_PFX5,
    IT_PFX4,
    IT_FIELD
  } item_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_ZERO
  } state_e;

  typedef struct packed {
    logic load;
    logic bit_step;
    logic zero_step;
  } cmd_t;

  typedef struct packed {
    logic bit_ended;
    logic bit_zero;
    logic zero_ended;
    logic zero_zero;
    logic last_bit;
    logic bits_done;
    logic slot_free;
  } sts_t;

  typedef struct packed {
    logic       ended;
    logic [4:0] step;
  } next_t;

  function automatic logic [4:0] last_step(input logic [1:0] kind);
    return (kind == KIND_RECT) ? 5'd4 : 5'd10;
  endfunction

  function automatic item_e item_type(input logic [1:0] kind, input logic [4:0] s,
                                      input logic [1:0] flags);
    item_e t;
    t = IT_NONE;
    if (kind == KIND_RECT) begin
      if (s == 5'd0) t = IT_PFX5;
      else if (s <= 5'd4) t = IT_FIELD;
    end else if (kind == KIND_MATRIX) begin
      if (s == 5'd0 || s == 5'd4) t = IT_FLAG;
      else if (s == 5'd1) t = flags[0] ? IT_PFX5 : IT_NONE;
      else if (s == 5'd2 || s == 5'd3) t = flags[0] ? IT_FIELD : IT_NONE;
      else if (s == 5'd5) t = flags[1] ? IT_PFX5 : IT_NONE;
      else if (s == 5'd6 || s == 5'd7) t = flags[1] ? IT_FIELD : IT_NONE;
      else if (s == 5'd8) t = IT_PFX5;
      else if (s == 5'd9 || s == 5'd10) t = IT_FIELD;
    end else begin
      if (s == 5'd0 || s == 5'd1) t = IT_FLAG;
      else if (s == 5'd2) t = IT_PFX4;
      else if (s >= 5'd3 && s <= 5'd6) begin
        if (flags[1] && !(s == 5'd6 && kind != KIND_CXA)) t = IT_FIELD;
      end else if (s >= 5'd7 && s <= 5'd10) begin
        if (flags[0] && !(s == 5'd10 && kind != KIND_CXA)) t = IT_FIELD;
      end
    end
    return t;
  endfunction

  function automatic logic [4:0] item_id(input logic [1:0] kind, input logic [4:0] s);
    logic [4:0] id;
    id = 5'd0;
    if (kind == KIND_RECT) id = s - 5'd1;
    else if (kind == KIND_MATRIX) begin
      if (s == 5'd2 || s == 5'd3) id = s + 5'd2;
      else if (s == 5'd6 || s == 5'd7) id = s;
      else id = s - 5'd1;
    end else begin
      if (s <= 5'd6) id = s + 5'd7;
      else id = s + 5'd7;
    end
    return id;
  endfunction

  function automatic next_t next_step(input logic [1:0] kind, input logic [4:0] s,
                                      input logic [1:0] flags);
    next_t n;
    logic found;
    found = 1'b0;
    n.ended = 1'b1;
    n.step = last_step(kind) + 5'd1;
    for (int i = 1; i <= 10; i++) begin
      if (!found && 5'(i) > s && 5'(i) <= last_step(kind) &&
          item_type(kind, 5'(i), flags) != IT_NONE) begin
        found = 1'b1;
        n.ended = 1'b0;
        n.step = 5'(i);
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/bprp_if.sv =====
// Valid/ready channel interfaces for the record bytes and the parsed fields.
// Depends on nothing.
interface bprp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] op;
  modport source (output valid, data_byte, op, input ready);
  modport sink (input valid, data_byte, op, output ready);
endinterface

interface bprp_out_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  field_id;
  logic signed [31:0] field_value;
  logic               last_field;
  modport source (output valid, field_id, field_value, last_field, input ready);
  modport sink (input valid, field_id, field_value, last_field, output ready);
endinterface

// ===== sv/bprp_ctrl.sv =====
// Controller state machine of the record parser: sequences bit and zero-width steps.
// Depends on bprp_pkg.
module bprp_ctrl
  import bprp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (sts_i.slot_free) begin
          cmd_o.bit_step = 1'b1;
          if (sts_i.bit_ended) state_d = S_IDLE;
          else if (sts_i.bit_zero) state_d = S_ZERO;
          else if (sts_i.last_bit) state_d = S_IDLE;
        end
      end
      S_ZERO: begin
        if (sts_i.slot_free) begin
          cmd_o.zero_step = 1'b1;
          if (sts_i.zero_ended) state_d = S_IDLE;
          else if (!sts_i.zero_zero) state_d = sts_i.bits_done ? S_IDLE : S_BIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/bprp_dp.sv =====
// Datapath of the record parser: record state, bit accumulator and output register.
// Depends on bprp_pkg.
module bprp_dp
  import bprp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MaxFieldBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [7:0]         data_byte_i,
  input  logic [1:0]         op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         field_id_o,
  output logic signed [31:0] field_value_o,
  output logic               last_field_o
);

  localparam logic [5:0] MaxW = 6'(MAX_FIELD_BITS);

  logic        in_rec_q, in_rec_d;
  logic [1:0]  kind_q, kind_d;
  logic [4:0]  step_q, step_d;
  logic [4:0]  width_q, width_d;
  logic [1:0]  flags_q, flags_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  left_q, left_d;
  logic        ov_q, ov_d;
  logic [4:0]  oid_q, oid_d;
  logic [31:0] oval_q, oval_d;
  logic        olast_q, olast_d;

  item_e       cur_t;
  logic [31:0] acc_n;
  logic [4:0]  cnt_n;
  logic [4:0]  len;
  logic        done;
  logic [1:0]  flags_n;
  logic [4:0]  width_n;
  logic [4:0]  pfx;
  next_t       nb, nz;
  logic [31:0] sext;
  logic [5:0]  nwidth;

  always_comb begin
    cur_t = item_type(kind_q, step_q, flags_q);
    acc_n = {acc_q[30:0], byte_q[7]};
    cnt_n = cnt_q + 5'd1;
    unique case (cur_t)
      IT_FLAG: len = 5'd1;
      IT_PFX5: len = 5'd5;
      IT_PFX4: len = 5'd4;
      default: len = width_q;
    endcase
    done = cnt_n >= len;
    flags_n = flags_q;
    width_n = width_q;
    pfx = (cur_t == IT_PFX5) ? acc_n[4:0] : {1'b0, acc_n[3:0]};
    if (cur_t == IT_FLAG) begin
      if (step_q == 5'd0) flags_n[0] = flags_q[0] | acc_n[0];
      else flags_n[1] = flags_q[1] | acc_n[0];
    end else if (cur_t == IT_PFX5 || cur_t == IT_PFX4) begin
      width_n = ({1'b0, pfx} > MaxW) ? MaxW[4:0] : pfx;
    end
    nb = next_step(kind_q, step_q, flags_n);
    nz = next_step(kind_q, step_q, flags_q);
    nwidth = 6'd32 - {1'b0, width_q};
    sext = acc_n;
    if (width_q != 5'd0 && acc_n[width_q - 5'd1]) sext = acc_n | (32'hFFFF_FFFF << width_q);

    sts_o.bit_ended  = done && nb.ended;
    sts_o.bit_zero   = done && !nb.ended && width_n == 5'd0 &&
                       item_type(kind_q, nb.step, flags_n) == IT_FIELD;
    sts_o.zero_ended = nz.ended;
    sts_o.zero_zero  = !nz.ended && width_q == 5'd0 &&
                       item_type(kind_q, nz.step, flags_q) == IT_FIELD;
    sts_o.last_bit   = left_q == 4'd1;
    sts_o.bits_done  = left_q == 4'd0;
    sts_o.slot_free  = !ov_q || out_ready_i;
  end

  always_comb begin
    in_rec_d = in_rec_q;
    kind_d = kind_q;
    step_d = step_q;
    width_d = width_q;
    flags_d = flags_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    byte_d = byte_q;
    left_d = left_q;
    ov_d = ov_q && !out_ready_i;
    oid_d = oid_q;
    oval_d = oval_q;
    olast_d = olast_q;
    if (cmd_i.load) begin
      byte_d = data_byte_i;
      left_d = 4'd8;
      if (!in_rec_q) begin
        in_rec_d = 1'b1;
        kind_d = op_i;
        step_d = '0;
        width_d = '0;
        flags_d = '0;
        acc_d = '0;
        cnt_d = '0;
      end
    end
    if (cmd_i.bit_step) begin
      byte_d = {byte_q[6:0], 1'b0};
      left_d = left_q - 4'd1;
      acc_d = acc_n;
      cnt_d = cnt_n;
      if (done) begin
        acc_d = '0;
        cnt_d = '0;
        flags_d = flags_n;
        width_d = width_n;
        step_d = nb.step;
        if (nb.ended) in_rec_d = 1'b0;
        if (cur_t == IT_FIELD) begin
          ov_d = 1'b1;
          oid_d = item_id(kind_q, step_q);
          oval_d = (nwidth == 6'd0) ? acc_n : sext;
          olast_d = nb.ended;
        end else if (nb.ended) begin
          ov_d = 1'b1;
          oid_d = IdEmpty;
          oval_d = '0;
          olast_d = 1'b1;
        end
      end
    end
    if (cmd_i.zero_step) begin
      step_d = nz.step;
      if (nz.ended) in_rec_d = 1'b0;
      ov_d = 1'b1;
      oid_d = item_id(kind_q, step_q);
      oval_d = '0;
      olast_d = nz.ended;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec_q <= 1'b0;
      kind_q <= '0;
      step_q <= '0;
      width_q <= '0;
      flags_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      left_q <= '0;
      ov_q <= 1'b0;
    end else begin
      in_rec_q <= in_rec_d;
      kind_q <= kind_d;
      step_q <= step_d;
      width_q <= width_d;
      flags_q <= flags_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      left_q <= left_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    oid_q <= oid_d;
    oval_q <= oval_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign field_id_o = oid_q;
  assign field_value_o = oval_q;
  assign last_field_o = olast_q;

endmodule

// ===== sv/bit_packed_record_parser_top.sv =====
// Bit-packed record parser top level. A byte is accepted in the idle state, then handled
// one bit per cycle up to the bit that ends the record, with a separate step for each
// zero-width field. A full output register stalls this bit-serial loop.
// Fields appear in the cycle after the bit that closes them. Reset clears all record state.
module bit_packed_record_parser_top
  import bprp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MaxFieldBitsDef
) (
  input logic           clk_i,
  input logic           rst_ni,
  bprp_in_if.sink       in_i,
  bprp_out_if.source    out_o
);

  cmd_t cmd;
  sts_t sts;

  bprp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bprp_dp #(.MAX_FIELD_BITS(MAX_FIELD_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (in_i.data_byte),
    .op_i          (in_i.op),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .field_id_o    (out_o.field_id),
    .field_value_o (out_o.field_value),
    .last_field_o  (out_o.last_field)
  );

endmodule

// ===== sv/bprp_checker.sv =====
// Port-level assertions for the record parser and the bind that attaches them.
// Depends on bprp_pkg and bit_packed_record_parser_top.
module bprp_checker
  import bprp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_id_i,
  input logic       out_last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("output item dropped");

  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_id_i <= IdEmpty) else $error("field id out of range");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_id_i == IdEmpty |-> out_last_i) else $error("empty marker not last");

endmodule

bind bit_packed_record_parser_top bprp_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_id_i    (out_o.field_id),
  .out_last_i  (out_o.last_field)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for bit_packed_record_parser_top: builds rect, matrix and
// color transform records as byte streams and checks every emitted field against a
// bit-serial field predictor. Depends on bprp_pkg, bprp_if.sv and the top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bprp_pkg::*;

  typedef enum int {SL_NONE, SL_FLAG, SL_W5, SL_W4, SL_VAL} slot_e;
  typedef enum int {FILL_RAND, FILL_ONES, FILL_SIGN, FILL_ZERO} fill_e;

  typedef struct {
    logic [7:0] data;
    logic [1:0] op;
  } byte_item_t;

  typedef struct {
    logic [4:0]  id;
    logic [31:0] value;
    logic        last;
  } field_t;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bprp_in_if  in_ch ();
  bprp_out_if out_ch ();

  bit_packed_record_parser_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  byte_item_t byte_q[$];
  field_t     field_q[$];
  bit         bit_q[$];
  int         errors = 0;
  int         sent = 0;
  int         cycles = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  int         snd_idle;
  int         rcv_idle;

  logic        p_in_rec;
  kind_e       p_kind;
  logic [4:0]  p_step;
  logic [4:0]  p_width;
  logic [1:0]  p_flags;
  logic [31:0] p_acc;
  logic [4:0]  p_cnt;

  task automatic add_field(logic [4:0] id, logic [31:0] value, logic last);
    field_t f;
    f.id    = id;
    f.value = value;
    f.last  = last;
    field_q.insert(field_q.size(), f);
  endtask

  task automatic add_bit(bit b);
    bit_q.insert(bit_q.size(), b);
  endtask

  task automatic add_byte(logic [7:0] data, logic [1:0] op);
    byte_item_t it;
    it.data = data;
    it.op   = op;
    byte_q.insert(byte_q.size(), it);
  endtask

  function automatic slot_e slot_at(kind_e k, logic [4:0] s, logic [1:0] f,
                                    output logic [4:0] id);
    id = 5'd0;
    if (k == KIND_RECT) begin
      if (s == 0) return SL_W5;
      id = s - 5'd1;
      return (s <= 4) ? SL_VAL : SL_NONE;
    end
    if (k == KIND_MATRIX) begin
      case (s)
        0, 4: return SL_FLAG;
        1: return f[0] ? SL_W5 : SL_NONE;
        2, 3: begin id = s + 5'd2; return f[0] ? SL_VAL : SL_NONE; end
        5: return f[1] ? SL_W5 : SL_NONE;
        6, 7: begin id = s; return f[1] ? SL_VAL : SL_NONE; end
        8: return SL_W5;
        9, 10: begin id = s - 5'd1; return SL_VAL; end
        default: return SL_NONE;
      endcase
    end
    if (s <= 1) return SL_FLAG;
    if (s == 2) return SL_W4;
    if (s <= 6) begin
      id = 5'd10 + s - 5'd3;
      if (!f[1] || (s == 6 && k != KIND_CXA)) return SL_NONE;
      return SL_VAL;
    end
    if (s <= 10) begin
      id = 5'd14 + s - 5'd7;
      if (!f[0] || (s == 10 && k != KIND_CXA)) return SL_NONE;
      return SL_VAL;
    end
    return SL_NONE;
  endfunction

  function automatic bit step_on();
    logic [4:0] id;
    int s;
    int last;
    s = p_step + 1;
    last = (p_kind == KIND_RECT) ? 4 : 10;
    while (s <= last && slot_at(p_kind, 5'(s), p_flags, id) == SL_NONE) s++;
    p_step = 5'(s);
    return s > last;
  endfunction

  function automatic logic [31:0] sext(logic [31:0] v, int n);
    logic [31:0] m;
    if (n == 0) return 32'd0;
    m = (32'd1 << n) - 32'd1;
    v = v & m;
    if (v[n-1]) v = v | ~m;
    return v;
  endfunction

  task automatic parse_byte(logic [7:0] data, logic [1:0] op);
    slot_e       t;
    logic [4:0]  id;
    logic [31:0] val;
    int          len;
    bit          ended;
    if (!p_in_rec) begin
      p_in_rec = 1'b1;
      p_kind   = kind_e'(op);
      p_step   = 0;
      p_width  = 0;
      p_flags  = 0;
      p_acc    = 0;
      p_cnt    = 0;
    end
    for (int b = 7; b >= 0 && p_in_rec; b--) begin
      t = slot_at(p_kind, p_step, p_flags, id);
      p_acc = {p_acc[30:0], data[b]};
      p_cnt = p_cnt + 5'd1;
      case (t)
        SL_FLAG: len = 1;
        SL_W5:   len = 5;
        SL_W4:   len = 4;
        default: len = p_width;
      endcase
      if (p_cnt < len) continue;
      val   = p_acc;
      p_acc = 0;
      p_cnt = 0;
      if (t == SL_FLAG) p_flags[p_step != 0] = val[0];
      else if (t == SL_W5) p_width = val[4:0];
      else if (t == SL_W4) p_width = {1'b0, val[3:0]};
      ended = step_on();
      if (t == SL_VAL) add_field(id, sext(val, p_width), ended);
      else if (ended) add_field(IdEmpty, 32'd0, 1'b1);
      while (!ended && p_width == 0 && slot_at(p_kind, p_step, p_flags, id) == SL_VAL) begin
        ended = step_on();
        add_field(id, 32'd0, ended);
      end
      if (ended) p_in_rec = 1'b0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("error at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  task automatic push_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_bit(v[i]);
  endtask

  task automatic push_field(int n, fill_e mode);
    logic [31:0] v;
    case (mode)
      FILL_ONES: v = '1;
      FILL_SIGN: v = (n > 0) ? (32'd1 << (n - 1)) : 32'd0;
      FILL_ZERO: v = 0;
      default: v = $urandom();
    endcase
    push_bits(v, n);
  endtask

  task automatic build_record(kind_e k, logic [1:0] f, int w0, int w1, int w2, fill_e mode);
    byte_item_t it;
    bit_q.delete();
    case (k)
      KIND_RECT: begin
        push_bits(w0, 5);
        repeat (4) push_field(w0, mode);
      end
      KIND_MATRIX: begin
        push_bits(f[0], 1);
        if (f[0]) begin push_bits(w0, 5); repeat (2) push_field(w0, mode); end
        push_bits(f[1], 1);
        if (f[1]) begin push_bits(w1, 5); repeat (2) push_field(w1, mode); end
        push_bits(w2, 5);
        repeat (2) push_field(w2, mode);
      end
      default: begin
        push_bits(f[0], 1);
        push_bits(f[1], 1);
        push_bits(w0 & 15, 4);
        if (f[1]) repeat ((k == KIND_CXA) ? 4 : 3) push_field(w0 & 15, mode);
        if (f[0]) repeat ((k == KIND_CXA) ? 4 : 3) push_field(w0 & 15, mode);
      end
    endcase
    while (bit_q.size() % 8 != 0) add_bit(1'($urandom()));
    for (int i = 0; i < bit_q.size(); i += 8) begin
      for (int j = 0; j < 8; j++) it.data[7-j] = bit_q[i+j];
      it.op = (i == 0) ? k : 2'($urandom());
      add_byte(it.data, it.op);
    end
  endtask

  function automatic int pick_width();
    if ($urandom_range(15) == 0) return 31;
    return $urandom_range(0, 8);
  endfunction

  always @(posedge clk_i) begin
    if (sent < 160) begin snd_idle = 13; rcv_idle = 56; end
    else if (sent < 320) begin snd_idle = 56; rcv_idle = 13; end
    else begin snd_idle = 0; rcv_idle = 0; end
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, in_ch.op);
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= byte_q[0].data;
          in_ch.op        <= byte_q[0].op;
          void'(byte_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (!hold_done && sent >= 200) begin
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    field_t e;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (field_q.size() == 0) begin
          report("unexpected field id", out_ch.field_id, 0);
        end else begin
          e = field_q.pop_front();
          if (out_ch.field_id !== e.id) report("field_id", out_ch.field_id, e.id);
          if (out_ch.field_value !== e.value)
            report("field_value", out_ch.field_value, e.value);
          if (out_ch.last_field !== e.last) report("last_field", out_ch.last_field, e.last);
        end
      end
      out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bit_packed_record_parser_top: mismatch");
      $finish;
    end
  end

  initial begin
    kind_e k;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.op        = 2'd0;
    out_ch.ready    = 1'b0;
    p_in_rec = 0;
    p_kind   = KIND_RECT;
    p_step   = 0;
    p_width  = 0;
    p_flags  = 0;
    p_acc    = 0;
    p_cnt    = 0;

    build_record(KIND_RECT, 2'd0, 0, 0, 0, FILL_RAND);
    build_record(KIND_RECT, 2'd0, 31, 0, 0, FILL_ONES);
    build_record(KIND_RECT, 2'd0, 31, 0, 0, FILL_SIGN);
    build_record(KIND_RECT, 2'd0, 3, 0, 0, FILL_ZERO);
    build_record(KIND_MATRIX, 2'd0, 0, 0, 0, FILL_RAND);
    build_record(KIND_MATRIX, 2'd3, 17, 0, 1, FILL_ONES);
    build_record(KIND_CX, 2'd0, 5, 0, 0, FILL_RAND);
    build_record(KIND_CX, 2'd1, 15, 0, 0, FILL_SIGN);
    build_record(KIND_CXA, 2'd3, 0, 0, 0, FILL_RAND);
    build_record(KIND_CXA, 2'd2, 15, 0, 0, FILL_ONES);
    build_record(KIND_CXA, 2'd0, 0, 0, 0, FILL_RAND);
    while (byte_q.size() < 480) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom()), 2'($urandom()));
      end else begin
        k = kind_e'($urandom_range(3));
        build_record(k, 2'($urandom()), pick_width(), pick_width(), pick_width(),
                     ($urandom_range(0, 5) < 3) ? FILL_RAND
                                                : fill_e'($urandom_range(1, 3)));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (byte_q.size() != 0 || in_ch.valid);
    do @(posedge clk_i); while (field_q.size() != 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("bit_packed_record_parser_top: match");
    end else begin
      $display("bit_packed_record_parser_top: mismatch");
    end
    $finish;
  end
endmodule
